@@ hw/rtl/fpfa_pkg.sv @@
// Shared types and constants for the fixed partition fit allocator.
// Used by fpfa_best and fixed_partition_fit_allocator; depends on nothing.
package fpfa_pkg;

    // Fixed field widths of the stream words
    localparam int IN_IDX_W  = 6;
    localparam int SIZE_W    = 16;
    localparam int COUNT_W   = 7;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 40;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PART_COUNT = 1'b1;
    localparam int CFG_DATA_W = 7;

    // Fit modes
    localparam logic MODE_WORST = 1'b0;
    localparam logic MODE_BEST  = 1'b1;

    // Input word kinds
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_ALLOC = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_ALLOC  = 2'd1,
        ST_NOFIT  = 2'd2
    } status_t;

    // Scan control from the sequencer to the best-candidate tracker
    typedef struct packed {
        logic clear;   // start of a new search
        logic sample;  // memory read data is a candidate this cycle
    } scan_ctl_t;

endpackage

@@ hw/rtl/fixed_partition_fit_allocator.sv @@
// Fixed partition fit allocator: load words write a partition size and free it;
// allocate words pick the largest (worst fit) or smallest (best fit) free
// partition that holds the request, lowest index on ties, and mark it used.
// After reset the block clears the used marks in the table memory and takes
// no input word meanwhile (configuration writes are taken). A load word goes
// from acceptance straight to the done state, and so does an allocate word
// while partition_count is zero. Otherwise an allocate word scans
// min(partition_count, PARTITIONS) entries: the scan reads one table entry
// per cycle through the single read port of the memory, then the drain state
// drains the read pipeline and the done state, once the output register is
// free, writes the used mark and the result. One word is worked on at a time;
// a finished result waits in the output register while the next word is
// accepted. Depends on fpfa_pkg, fpfa_mem and fpfa_best.
module fixed_partition_fit_allocator
    import fpfa_pkg::*;
#(
    parameter int PARTITIONS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [5:0] partition_index, [21:6] size_value
    input  logic                  s_tuser,   // [0] func
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [5:0] chosen_index, [21:6] chosen_size,
                                             // [37:22] leftover
    output logic [1:0]            m_tuser    // [1:0] status
);

    localparam int IDX_W  = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int CNT_W  = $clog2(PARTITIONS + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int WORD_W = SIZE_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    // Unpacked input fields
    logic [IN_IDX_W-1:0] in_idx;
    logic [SIZE_W-1:0]   in_size;

    assign in_idx  = s_tdata[IN_IDX_W-1:0];
    assign in_size = s_tdata[IN_IDX_W +: SIZE_W];

    // Configuration registers
    logic               fit_mode_reg;
    logic [COUNT_W-1:0] part_count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg   <= MODE_WORST;
            part_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FIT_MODE:   fit_mode_reg   <= cfg_data[0];
                REG_PART_COUNT: part_count_reg <= cfg_data[COUNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Sequencer state
    state_t              state_reg,    state_next;
    logic [CNT_W-1:0]    addr_reg,     addr_next;
    logic [CNT_W-1:0]    limit_reg,    limit_next;
    logic [SIZE_W-1:0]   req_reg,      req_next;
    logic                alloc_reg,    alloc_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]    rd_idx_reg,   rd_idx_next;
    logic                m_tvalid_reg, m_tvalid_next;
    status_t             status_reg,   status_next;
    logic [IN_IDX_W-1:0] o_idx_reg,    o_idx_next;
    logic [SIZE_W-1:0]   o_size_reg,   o_size_next;
    logic [SIZE_W-1:0]   o_left_reg,   o_left_next;

    // Memory ports
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [WORD_W-1:0] rd_data;

    // Tracker
    scan_ctl_t         scan_ctl;
    logic              found;
    logic [IDX_W-1:0]  best_idx;
    logic [SIZE_W-1:0] best_size;

    logic [CMP_W-1:0]  count_ext;
    logic [CMP_W-1:0]  clamped;
    logic [CNT_W-1:0]  addr_inc;
    logic              in_accept;
    logic              out_free;

    fpfa_mem #(
        .DEPTH  (PARTITIONS),
        .ADDR_W (IDX_W),
        .DATA_W (WORD_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    fpfa_best #(
        .IDX_W (IDX_W)
    ) u_best (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .fit_mode  (fit_mode_reg),
        .req_size  (req_reg),
        .cand_idx  (rd_idx_reg),
        .cand_used (rd_data[SIZE_W]),
        .cand_size (rd_data[SIZE_W-1:0]),
        .found     (found),
        .best_idx  (best_idx),
        .best_size (best_size)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign addr_inc  = addr_reg + CNT_W'(1);

    // Search limit: partition_count clamped to the table depth
    always_comb
    begin
        count_ext = CMP_W'(part_count_reg);
        clamped   = (count_ext > CMP_W'(PARTITIONS)) ? CMP_W'(PARTITIONS) : count_ext;
    end

    // Next-state and memory port logic
    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        limit_next    = limit_reg;
        req_next      = req_reg;
        alloc_next    = alloc_reg;
        rd_valid_next = 1'b0;
        rd_idx_next   = rd_idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        status_next   = status_reg;
        o_idx_next    = o_idx_reg;
        o_size_next   = o_size_reg;
        o_left_next   = o_left_reg;

        wr_en    = 1'b0;
        wr_addr  = addr_reg[IDX_W-1:0];
        wr_data  = '0;
        rd_en    = 1'b0;
        rd_addr  = addr_reg[IDX_W-1:0];
        scan_ctl = '{clear: 1'b0, sample: rd_valid_reg};

        case (state_reg)
            // Sweep the table once, marking every partition free
            S_CLEAR:
            begin
                wr_en     = 1'b1;
                addr_next = addr_inc;
                if (addr_inc == CNT_W'(PARTITIONS))
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_accept)
                begin
                    req_next   = in_size;
                    alloc_next = (s_tuser == FUNC_ALLOC);
                    addr_next  = '0;
                    limit_next = CNT_W'(clamped);
                    scan_ctl.clear = 1'b1;
                    if (s_tuser == FUNC_LOAD)
                    begin
                        wr_en      = (CMP_W'(in_idx) < CMP_W'(PARTITIONS));
                        wr_addr    = IDX_W'(in_idx);
                        wr_data    = {1'b0, in_size};
                        state_next = S_DONE;
                    end
                    else if (clamped == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            // One table read per cycle
            S_SCAN:
            begin
                rd_en         = 1'b1;
                rd_valid_next = 1'b1;
                rd_idx_next   = addr_reg[IDX_W-1:0];
                addr_next     = addr_inc;
                if (addr_inc == limit_reg)
                begin
                    state_next = S_DRAIN;
                end
            end

            // Last read data reaches the tracker
            S_DRAIN:
            begin
                state_next = S_DONE;
            end

            // Mark the winner used and post the result
            S_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    o_idx_next    = '0;
                    o_size_next   = '0;
                    o_left_next   = '0;
                    if (!alloc_reg)
                    begin
                        status_next = ST_LOADED;
                    end
                    else if (found)
                    begin
                        status_next = ST_ALLOC;
                        o_idx_next  = IN_IDX_W'(best_idx);
                        o_size_next = best_size;
                        o_left_next = best_size - req_reg;
                        wr_en       = 1'b1;
                        wr_addr     = best_idx;
                        wr_data     = {1'b1, best_size};
                    end
                    else
                    begin
                        status_next = ST_NOFIT;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            addr_reg     <= '0;
            limit_reg    <= '0;
            alloc_reg    <= 1'b0;
            rd_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            status_reg   <= ST_LOADED;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            limit_reg    <= limit_next;
            alloc_reg    <= alloc_next;
            rd_valid_reg <= rd_valid_next;
            m_tvalid_reg <= m_tvalid_next;
            status_reg   <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rd_idx_reg <= rd_idx_next;
        o_idx_reg  <= o_idx_next;
        o_size_reg <= o_size_next;
        o_left_reg <= o_left_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {{(M_TDATA_W - IN_IDX_W - 2*SIZE_W){1'b0}},
                       o_left_reg, o_size_reg, o_idx_reg};

    // A table write never shares a cycle with a scan read
    assert property (@(posedge clk) disable iff (!rst_n) !(wr_en && rd_en))
        else $error("table write during scan read");

    // A winner always lies inside the searched range
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && alloc_reg && found |->
            (CNT_W'(best_idx) < limit_reg))
        else $error("winner outside search range");

    // An allocation never reports more leftover than the partition holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_ALLOC) |-> (o_left_reg <= o_size_reg))
        else $error("leftover exceeds partition size");

    // Load and no-fit results carry zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == ST_NOFIT) || (m_tuser == ST_LOADED)) |-> (m_tdata == '0))
        else $error("nonzero fields on load or no-fit result");

endmodule

@@ hw/rtl/fpfa_mem.sv @@
// Partition table memory: one write port, one read port, registered read data.
// Each word holds the used mark above the partition size. No dependencies.
module fpfa_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 17
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/fpfa_best.sv @@
// Best-candidate tracker: keeps the worst-fit or best-fit winner of a scan.
// Depends on fpfa_pkg for the scan control struct and field widths.
module fpfa_best
    import fpfa_pkg::*;
#(
    parameter int IDX_W = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  scan_ctl_t         ctl,
    input  logic              fit_mode,
    input  logic [SIZE_W-1:0] req_size,
    input  logic [IDX_W-1:0]  cand_idx,
    input  logic              cand_used,
    input  logic [SIZE_W-1:0] cand_size,
    output logic              found,
    output logic [IDX_W-1:0]  best_idx,
    output logic [SIZE_W-1:0] best_size
);

    logic              found_reg;
    logic              found_next;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [IDX_W-1:0]  best_idx_next;
    logic [SIZE_W-1:0] best_size_reg;
    logic [SIZE_W-1:0] best_size_next;
    logic              fits;
    logic              better;

    // Candidate test: free, large enough, strictly better (ties keep lower index)
    always_comb
    begin
        fits   = !cand_used && (cand_size >= req_size);
        better = !found_reg
              || ((fit_mode == MODE_WORST) && (cand_size > best_size_reg))
              || ((fit_mode == MODE_BEST)  && (cand_size < best_size_reg));

        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_size_next = best_size_reg;
        if (ctl.clear)
        begin
            found_next = 1'b0;
        end
        else if (ctl.sample && fits && better)
        begin
            found_next     = 1'b1;
            best_idx_next  = cand_idx;
            best_size_next = cand_size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_size_reg <= best_size_next;
    end

    assign found     = found_reg;
    assign best_idx  = best_idx_reg;
    assign best_size = best_size_reg;

endmodule

@@ bench/tb.sv @@
// Self-checking bench for fixed_partition_fit_allocator: directed table, then random phases.
// Every result word is checked against an in-bench fit predictor or a typed expectation.
// Depends on fpfa_pkg and the allocator RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fpfa_pkg::*;

    localparam int PARTS       = 64;
    localparam int STALL_LIMIT = 4000;

    // Expected result word
    typedef struct packed {
        status_t     status;
        logic [5:0]  chosen_index;
        logic [15:0] chosen_size;
        logic [15:0] leftover;
    } fit_result_t;

    // One row of the directed table: a register write or an input word
    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  func;
        logic [5:0]            idx;
        logic [15:0]           size;
        logic                  typed;
        fit_result_t           want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // [5:0] partition_index, [21:6] size_value
    logic                  s_tuser = 1'b0; // [0] func
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;        // [5:0] chosen_index, [21:6] chosen_size,
                                           // [37:22] leftover
    logic [1:0]            m_tuser;        // [1:0] status

    // Predictor state
    logic [15:0] tbl_size [PARTS];
    bit          tbl_used [PARTS];
    bit          tbl_loaded [PARTS];
    logic        cur_mode = MODE_WORST;
    logic [6:0]  cur_count = '0;

    fit_result_t expected_results [$];
    dir_row_t    dir_rows [$];
    int          errors = 0;
    int          stall_cycles = 0;
    bit          idle_on = 1'b1;

    fixed_partition_fit_allocator #(.PARTITIONS(PARTS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    // Fit predictor: applies one input word to the table copy, returns its result
    function automatic fit_result_t fit_result(input logic func, input logic [5:0] idx,
                                               input logic [15:0] req);
        fit_result_t r;
        int          lim;
        bit          found;
        int          pick;
        logic [15:0] pick_size;
        r = '0;
        r.status = ST_LOADED;
        if (func == FUNC_LOAD)
        begin
            tbl_size[idx]   = req;
            tbl_used[idx]   = 1'b0;
            tbl_loaded[idx] = 1'b1;
            return r;
        end
        lim = (cur_count > PARTS) ? PARTS : int'(cur_count);
        found = 1'b0;
        pick = 0;
        pick_size = '0;
        for (int i = 0; i < lim; i++)
        begin
            if (!tbl_used[i] && tbl_size[i] >= req)
            begin
                if (!found || (cur_mode == MODE_WORST && tbl_size[i] > pick_size) ||
                    (cur_mode == MODE_BEST && tbl_size[i] < pick_size))
                begin
                    found = 1'b1;
                    pick = i;
                    pick_size = tbl_size[i];
                end
            end
        end
        if (!found)
        begin
            r.status = ST_NOFIT;
            return r;
        end
        tbl_used[pick] = 1'b1;
        r.status       = ST_ALLOC;
        r.chosen_index = pick[5:0];
        r.chosen_size  = pick_size;
        r.leftover     = pick_size - req;
        return r;
    endfunction

    // Directed table builders
    function automatic void row_item(input logic func, input logic [5:0] idx,
                                     input logic [15:0] size);
        dir_row_t r;
        r = '0;
        r.func = func;
        r.idx  = idx;
        r.size = size;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_typed(input logic func, input logic [5:0] idx,
                                      input logic [15:0] size, input status_t st,
                                      input logic [5:0] ci, input logic [15:0] cs,
                                      input logic [15:0] lo);
        dir_row_t r;
        r = '0;
        r.func  = func;
        r.idx   = idx;
        r.size  = size;
        r.typed = 1'b1;
        r.want.status       = st;
        r.want.chosen_index = ci;
        r.want.chosen_size  = cs;
        r.want.leftover     = lo;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_cfg(input logic [CFG_IDX_W-1:0] ri,
                                    input logic [CFG_DATA_W-1:0] val);
        dir_row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.reg_idx = ri;
        r.reg_val = val;
        dir_rows.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    // Drive one input word, then record its expectation once it is taken
    task automatic send_item(input logic func, input logic [5:0] idx, input logic [15:0] size,
                             input bit typed, input fit_result_t typed_res);
        fit_result_t res;
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 19)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {2'b00, size, idx};
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        res = fit_result(func, idx, size);
        expected_results.push_back(typed ? typed_res : res);
    endtask

    task automatic idle_sender();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Register write; only called with nothing in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] ri, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= ri;
        cfg_data  <= val;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        if (ri == REG_FIT_MODE)
            cur_mode = val[0];
        else
            cur_count = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result receiver: random stalls while idle_on is set
    always @(negedge clk)
        m_tready <= !idle_on || ($urandom_range(99) >= 19);

    // Result checker
    always @(posedge clk)
    begin : result_check
        fit_result_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result word with none pending", m_tdata, 0);
            else
            begin
                want = expected_results.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", m_tuser, want.status);
                if (m_tdata[5:0] !== want.chosen_index)
                    report_mismatch("chosen_index", m_tdata[5:0], want.chosen_index);
                if (m_tdata[21:6] !== want.chosen_size)
                    report_mismatch("chosen_size", m_tdata[21:6], want.chosen_size);
                if (m_tdata[37:22] !== want.leftover)
                    report_mismatch("leftover", m_tdata[37:22], want.leftover);
            end
        end
    end

    // Watchdog on cycles with no word moving anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[fixed_partition_fit_allocator] ERROR");
            $finish;
        end
    end

    initial
    begin
        fit_result_t blank;
        dir_row_t    row;
        logic        func;
        logic [5:0]  idx;
        logic [15:0] size;
        logic [6:0]  cnt;
        int          lim;
        int          hole;
        int          pick;

        blank = '0;
        for (int i = 0; i < PARTS; i++)
        begin
            tbl_size[i]   = '0;
            tbl_used[i]   = 1'b0;
            tbl_loaded[i] = 1'b0;
        end

        // Directed table
        row_typed(FUNC_ALLOC, 6'd0, 16'd0, ST_NOFIT, 6'd0, 16'd0, 16'd0);  // count zero
        row_typed(FUNC_LOAD, 6'd0, 16'hFFFF, ST_LOADED, 6'd0, 16'd0, 16'd0);
        row_typed(FUNC_LOAD, 6'd63, 16'd0, ST_LOADED, 6'd0, 16'd0, 16'd0);
        row_item(FUNC_LOAD, 6'd1, 16'd0);
        row_item(FUNC_LOAD, 6'd2, 16'd100);
        row_item(FUNC_LOAD, 6'd3, 16'd100);
        row_cfg(REG_PART_COUNT, 7'd4);
        row_typed(FUNC_ALLOC, 6'd0, 16'hFFFF, ST_ALLOC, 6'd0, 16'hFFFF, 16'd0);
        row_item(FUNC_ALLOC, 6'h3F, 16'd50);    // tie on 100, lowest index wins
        row_item(FUNC_ALLOC, 6'd21, 16'd101);   // no fit
        row_item(FUNC_ALLOC, 6'd0, 16'd0);      // zero request
        row_item(FUNC_ALLOC, 6'd0, 16'd0);      // zero request into a zero size
        row_item(FUNC_ALLOC, 6'd0, 16'd0);      // all used
        row_item(FUNC_LOAD, 6'd2, 16'h5555);    // reload frees
        row_item(FUNC_LOAD, 6'd1, 16'd7);
        row_cfg(REG_FIT_MODE, {6'd0, MODE_BEST});
        row_item(FUNC_ALLOC, 6'd0, 16'd5);
        row_item(FUNC_ALLOC, 6'd0, 16'h5556);
        row_item(FUNC_LOAD, 6'd0, 16'h8000);
        row_item(FUNC_LOAD, 6'd1, 16'h8000);
        row_item(FUNC_ALLOC, 6'd0, 16'h8000);   // best-fit tie
        row_cfg(REG_FIT_MODE, {6'd0, MODE_WORST});

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[k])
        begin
            row = dir_rows[k];
            if (row.is_cfg)
            begin
                idle_sender();
                wait_drain();
                write_reg(row.reg_idx, row.reg_val);
            end
            else
                send_item(row.func, row.idx, row.size, row.typed, row.want);
        end

        // Random phases, each with its own register setting
        for (int ph = 0; ph < 8; ph++)
        begin
            idle_sender();
            wait_drain();
            case (ph)
                0: cnt = 7'd64;
                1: cnt = 7'd127;
                2: cnt = 7'd0;
                3: cnt = 7'd65;
                4: cnt = 7'($urandom_range(64, 1));
                5: cnt = 7'd1;
                6: cnt = 7'($urandom_range(12, 2));
                default: cnt = 7'($urandom_range(127, 0));
            endcase
            write_reg(REG_FIT_MODE, {6'($urandom_range(63)), (ph % 2 == 1) ? MODE_BEST : MODE_WORST});
            write_reg(REG_PART_COUNT, cnt);
            idle_on = (ph != 4);

            for (int n = 0; n < 200; n++)
            begin
                // one drain pause with the sender held off
                if (ph == 1 && n == 100)
                begin
                    idle_sender();
                    wait_drain();
                end
                lim = (cur_count > PARTS) ? PARTS : int'(cur_count);
                hole = lim;
                for (int i = lim - 1; i >= 0; i--)
                    if (!tbl_loaded[i])
                        hole = i;
                pick = (lim > 0) ? $urandom_range(lim - 1) : 0;
                idx = 6'($urandom_range(63));

                if (hole < lim)
                begin
                    // searched range must be loaded before any allocate
                    func = FUNC_LOAD;
                    idx  = hole[5:0];
                    size = 16'($urandom());
                end
                else if ($urandom_range(99) < 45)
                begin
                    func = FUNC_ALLOC;
                    case ($urandom_range(3))
                        0: size = 16'($urandom());
                        1: size = tbl_size[pick];
                        2: size = (tbl_size[pick] > 16'd8) ?
                                  tbl_size[pick] - 16'($urandom_range(8)) : tbl_size[pick];
                        default: size = 16'($urandom_range(3));
                    endcase
                end
                else
                begin
                    func = FUNC_LOAD;
                    if (lim > 0 && $urandom_range(3) != 0)
                        idx = pick[5:0];
                    case ($urandom_range(3))
                        0: size = 16'($urandom());
                        1: size = 16'($urandom_range(64));
                        2: size = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                        default: size = 16'($urandom_range(16'h9000, 16'h7000));
                    endcase
                end
                send_item(func, idx, size, 1'b0, blank);
            end
        end

        // Drain and let the pipeline settle
        idle_sender();
        wait_drain();
        repeat (PARTS + 8) @(posedge clk);
        if (errors == 0)
            $display("[fixed_partition_fit_allocator] OK");
        else
            $display("[fixed_partition_fit_allocator] ERROR");
        $finish;
    end

endmodule
